>>> rtl/core/keyed_entry_table_defines.svh
// Assertion macros used by the keyed entry table checker.
`ifndef KEYED_ENTRY_TABLE_DEFINES_SVH
`define KEYED_ENTRY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KET_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyed_entry_table: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyed_entry_table: next-cycle check failed");

`endif

>>> rtl/core/ket_pkg.sv
// Types and constants of the keyed entry table.
package ket_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned PayW  = 64;
  localparam int unsigned CntW  = 7;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned StatW = 2;

  localparam logic [CntW-1:0] CountMax = 7'd127;

  typedef enum logic [CmdW-1:0] {
    CmdAdd     = 3'd0,
    CmdGet     = 3'd1,
    CmdRemove  = 3'd2,
    CmdStats   = 3'd3,
    CmdCompact = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SInit,
    SIdle,
    SScan,
    SSweep,
    SDone
  } state_e;

  typedef struct packed {
    logic            occ;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] payload;
  } entry_t;

  typedef struct packed {
    status_e         status;
    logic [PayW-1:0] found_payload;
    logic [CntW-1:0] valid_count;
    logic [CntW-1:0] empty_count;
  } rsp_t;

endpackage

>>> rtl/core/ket_if.sv
// Request and response channel interfaces of the keyed entry table.
interface ket_req_if;
  logic                      valid;
  logic                      ready;
  logic [ket_pkg::CmdW-1:0]  cmd;
  logic [ket_pkg::KeyW-1:0]  entry_key;
  logic [ket_pkg::PayW-1:0]  entry_payload;

  modport source (output valid, output cmd, output entry_key, output entry_payload,
                  input ready);
  modport sink   (input valid, input cmd, input entry_key, input entry_payload,
                  output ready);
endinterface

interface ket_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ket_pkg::StatW-1:0] status;
  logic [ket_pkg::PayW-1:0]  found_payload;
  logic [ket_pkg::CntW-1:0]  valid_count;
  logic [ket_pkg::CntW-1:0]  empty_count;

  modport source (output valid, output status, output found_payload,
                  output valid_count, output empty_count, input ready);
  modport sink   (input valid, input status, input found_payload,
                  input valid_count, input empty_count, output ready);
endinterface

>>> rtl/core/keyed_entry_table.sv
// Keyed entry table top level: memory, scan sequencer and response register.
// One request at a time. Every request reads the whole table through the single
// read port of the entry memory, one entry per cycle; compact then also marks
// the tail beyond the occupied entries empty. After reset a clearing pass holds
// off the first request. A finished response waits in an output register, so
// the next request can be accepted while it is still pending; a request that
// finishes while the previous response still waits stalls until that response
// is taken.
module keyed_entry_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ket_req_if.sink    req_i,
  ket_rsp_if.source  rsp_o
);
  import ket_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned SW = (IW > CntW) ? IW : CntW;
  localparam logic [IW-1:0] DepthI = IW'(DEPTH);

  function automatic logic [CntW-1:0] sat_cnt(input logic [IW-1:0] c);
    logic [SW-1:0] w;
    w = SW'(c);
    return (w > SW'(CountMax)) ? CountMax : w[CntW-1:0];
  endfunction

  state_e          state_q, state_d;
  cmd_e            cmd_q;
  logic [KeyW-1:0] key_q;
  logic [PayW-1:0] pay_q;
  logic [IW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   occ_q, occ_d;
  logic            rd_vld_q, rd_vld_d;
  logic [AW-1:0]   rd_idx_q, rd_idx_d;
  logic            hit_q, hit_d;
  logic [AW-1:0]   hit_idx_q, hit_idx_d;
  logic [PayW-1:0] hit_pay_q, hit_pay_d;
  logic            out_vld_q, out_vld_d;
  rsp_t            out_q, res;

  entry_t          mem [DEPTH];
  entry_t          rd_data_q;
  logic            mem_re, mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  logic            req_fire, load_out, scan_end, key_eq, cand;

  assign req_fire = req_i.valid && req_i.ready;
  assign scan_end = (cnt_q == DepthI) && !rd_vld_q;
  assign key_eq   = rd_data_q.key == key_q;
  assign cand     = (cmd_q == CmdAdd) ? (!rd_data_q.occ || key_eq)
                                      : (rd_data_q.occ && key_eq);

  // entry memory with a registered read port
  always_ff @(posedge clk_i) begin
    if (mem_re) rd_data_q <= mem[cnt_q[AW-1:0]];
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SInit:   if (cnt_q == DepthI) state_d = SIdle;
      SIdle:   if (req_i.valid) state_d = SScan;
      SScan:   if (scan_end) state_d = (cmd_q == CmdCompact) ? SSweep : SDone;
      SSweep:  if (cnt_q == DepthI) state_d = SDone;
      SDone:   if (!out_vld_q || rsp_o.ready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    occ_d       = occ_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_pay_d   = hit_pay_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[AW-1:0];
    mem_wdata   = '{occ: 1'b0, key: key_q, payload: pay_q};
    req_i.ready = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      SInit, SSweep: begin
        if (cnt_q != DepthI) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      SIdle: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          cnt_d = '0;
          occ_d = '0;
          hit_d = 1'b0;
        end
      end
      SScan: begin
        if (cnt_q != DepthI) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[AW-1:0];
          cnt_d    = cnt_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (rd_data_q.occ) begin
            occ_d = occ_q + 1'b1;
            if (cmd_q == CmdCompact) begin
              mem_we    = 1'b1;
              mem_waddr = occ_q[AW-1:0];
              mem_wdata = rd_data_q;
            end
          end
          if (cand && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
            hit_pay_d = rd_data_q.payload;
          end
        end
        if (scan_end) begin
          mem_waddr = hit_idx_q;
          if (cmd_q == CmdAdd && hit_q) begin
            mem_we    = 1'b1;
            mem_wdata = '{occ: 1'b1, key: key_q, payload: pay_q};
          end
          if (cmd_q == CmdRemove && hit_q) mem_we = 1'b1;
          if (cmd_q == CmdCompact) cnt_d = occ_q;
        end
      end
      SDone: begin
        if (!out_vld_q || rsp_o.ready) load_out = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res = '{status: StOk, found_payload: '0, valid_count: '0, empty_count: '0};
    unique case (cmd_q)
      CmdAdd: if (!hit_q) res.status = StFull;
      CmdGet: begin
        if (hit_q) res.found_payload = hit_pay_q;
        else       res.status        = StNotFound;
      end
      CmdRemove: if (!hit_q) res.status = StNotFound;
      CmdStats: begin
        res.valid_count = sat_cnt(occ_q);
        res.empty_count = sat_cnt(DepthI - occ_q);
      end
      default: ;
    endcase
  end

  assign out_vld_d = load_out || (out_vld_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SInit;
      cnt_q     <= '0;
      occ_q     <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      occ_q     <= occ_d;
      rd_vld_q  <= rd_vld_d;
      hit_q     <= hit_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q <= cmd_e'(req_i.cmd);
      key_q <= req_i.entry_key;
      pay_q <= req_i.entry_payload;
    end
    rd_idx_q  <= rd_idx_d;
    hit_idx_q <= hit_idx_d;
    hit_pay_q <= hit_pay_d;
    if (load_out) out_q <= res;
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.found_payload = out_q.found_payload;
  assign rsp_o.valid_count   = out_q.valid_count;
  assign rsp_o.empty_count   = out_q.empty_count;

endmodule

>>> rtl/core/ket_chk.sv
// Port-level assertion checker for the keyed entry table, with its bind.
`include "keyed_entry_table_defines.svh"

module ket_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic [ket_pkg::StatW-1:0] status_i,
  input logic [ket_pkg::PayW-1:0]  found_payload_i,
  input logic [ket_pkg::CntW-1:0]  valid_count_i,
  input logic [ket_pkg::CntW-1:0]  empty_count_i
);
  import ket_pkg::*;

  `KET_ASSERT_NEXT(a_busy_after_req, req_valid_i && req_ready_i, !req_ready_i)
  `KET_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(status_i) && $stable(found_payload_i) && $stable(valid_count_i))
  `KET_ASSERT_NOW(a_err_clean, rsp_valid_i && status_i != StOk, found_payload_i == '0 && valid_count_i == '0 && empty_count_i == '0)
  `KET_ASSERT_NOW(a_pay_no_cnt, rsp_valid_i && found_payload_i != '0, valid_count_i == '0 && empty_count_i == '0)

endmodule

bind keyed_entry_table ket_chk u_ket_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .found_payload_i (rsp_o.found_payload),
  .valid_count_i   (rsp_o.valid_count),
  .empty_count_i   (rsp_o.empty_count)
);

>>> dv/tb.sv
// Self-checking testbench for keyed_entry_table: directed request table, then random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ket_pkg::*;

  localparam int unsigned Depth     = 64;
  localparam int unsigned PoolN     = 12;
  localparam int unsigned RandItems = 1830;
  localparam int unsigned PhaseLen  = 160;
  localparam int unsigned LogLimit  = 100;

  localparam logic [CmdW-1:0] CmdSpareLo = 3'd5;
  localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;

  typedef enum logic [1:0] {
    MixFill,
    MixBalanced,
    MixDrain
  } mix_e;

  typedef struct {
    logic [CmdW-1:0] cmd;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] payload;
    bit              fixed;
    status_e         status;
    logic [PayW-1:0] found_payload;
    logic [CntW-1:0] valid_count;
    logic [CntW-1:0] empty_count;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   steady = 1'b0;

  ket_req_if req_bus ();
  ket_rsp_if rsp_bus ();

  keyed_entry_table #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Table contents as seen by the predictor.
  bit              slot_used [Depth];
  logic [KeyW-1:0] slot_key  [Depth];
  logic [PayW-1:0] slot_pay  [Depth];

  logic [KeyW-1:0] key_pool [PoolN];
  rsp_t            pending_rsp_q [$];
  int unsigned     mismatch_cnt = 0;

  // Fixed rows carry their expected response; the others go through the predictor.
  step_t directed_steps [0:21] = '{
    '{CmdStats,   '0,           '0,           1'b1, StOk,       '0, '0, 7'(Depth)},
    '{CmdGet,     32'h0,        '0,           1'b1, StNotFound, '0, '0, '0},
    '{CmdRemove,  32'hFFFF_FFFF, '0,          1'b1, StNotFound, '0, '0, '0},
    '{CmdCompact, '0,           '0,           1'b1, StOk,       '0, '0, '0},
    '{CmdAdd,     32'h0,        64'h0,        1'b1, StOk,       '0, '0, '0},
    '{CmdAdd,     32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, StOk, '0, '0, '0},
    '{CmdGet,     32'hFFFF_FFFF, '0, 1'b1, StOk, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
    '{CmdGet,     32'h0,        64'hFFFF_FFFF_FFFF_FFFF, 1'b1, StOk, 64'h0, '0, '0},
    '{CmdAdd,     32'h0,        64'h0123_4567_89AB_CDEF, 1'b1, StOk, '0, '0, '0},
    '{CmdGet,     32'h0,        '0, 1'b1, StOk, 64'h0123_4567_89AB_CDEF, '0, '0},
    '{CmdAdd,     32'h0000_1234, 64'h5555_5555_5555_5555, 1'b0, StOk, '0, '0, '0},
    '{CmdRemove,  32'h0,        '0,           1'b1, StOk,       '0, '0, '0},
    // reuses the freed low slot, leaving a duplicate further up
    '{CmdAdd,     32'h0000_1234, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, StOk, '0, '0, '0},
    '{CmdGet,     32'h0000_1234, '0,          1'b0, StOk,       '0, '0, '0},
    '{CmdRemove,  32'h0000_1234, '0,          1'b0, StOk,       '0, '0, '0},
    '{CmdGet,     32'h0000_1234, '0,          1'b0, StOk,       '0, '0, '0},
    '{CmdStats,   '0,           '0,           1'b0, StOk,       '0, '0, '0},
    '{CmdCompact, '0,           '0,           1'b0, StOk,       '0, '0, '0},
    '{CmdStats,   '0,           '0,           1'b0, StOk,       '0, '0, '0},
    '{CmdGet,     32'hFFFF_FFFF, '0,          1'b0, StOk,       '0, '0, '0},
    '{CmdSpareLo, 32'h8000_0001, 64'h8000_0000_0000_0001, 1'b1, StOk, '0, '0, '0},
    '{CmdSpareHi, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, StOk, '0, '0, '0}
  };

  function automatic rsp_t apply_table_cmd(input logic [CmdW-1:0] op,
                                           input logic [KeyW-1:0] k,
                                           input logic [PayW-1:0] p);
    rsp_t r;
    int   hit;
    int   n;
    int   w;
    r   = '0;
    hit = Depth;
    n   = 0;
    w   = 0;
    case (op)
      CmdAdd: begin
        for (int i = 0; i < Depth; i++)
          if (hit == Depth && (!slot_used[i] || slot_key[i] == k)) hit = i;
        if (hit < Depth) begin
          slot_used[hit] = 1'b1;
          slot_key[hit]  = k;
          slot_pay[hit]  = p;
        end else begin
          r.status = StFull;
        end
      end
      CmdGet, CmdRemove: begin
        for (int i = 0; i < Depth; i++)
          if (hit == Depth && slot_used[i] && slot_key[i] == k) hit = i;
        if (hit == Depth) r.status = StNotFound;
        else if (op == CmdGet) r.found_payload = slot_pay[hit];
        else slot_used[hit] = 1'b0;
      end
      CmdStats: begin
        for (int i = 0; i < Depth; i++) n += int'(slot_used[i]);
        r.valid_count = (n > CountMax) ? CountMax : CntW'(n);
        r.empty_count = ((Depth - n) > CountMax) ? CountMax : CntW'(Depth - n);
      end
      CmdCompact: begin
        for (int i = 0; i < Depth; i++) begin
          if (slot_used[i]) begin
            slot_key[w] = slot_key[i];
            slot_pay[w] = slot_pay[i];
            w++;
          end
        end
        for (int i = 0; i < Depth; i++) slot_used[i] = (i < w);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [CmdW-1:0] pick_cmd(input mix_e mix);
    int r;
    int add_w;
    int rem_w;
    r     = $urandom_range(99);
    add_w = (mix == MixFill) ? 65 : (mix == MixDrain) ? 15 : 35;
    rem_w = (mix == MixDrain) ? 50 : (mix == MixFill) ? 8 : 25;
    if (r < add_w) return CmdAdd;
    if (r < add_w + rem_w) return CmdRemove;
    r = $urandom_range(99);
    if (r < 60) return CmdGet;
    if (r < 77) return CmdStats;
    if (r < 94) return CmdCompact;
    return CmdW'($urandom_range(CmdSpareHi, CmdSpareLo));
  endfunction

  // Mix of keys already stored, a small shared pool and fresh random keys.
  function automatic logic [KeyW-1:0] pick_key(input mix_e mix);
    int              r;
    int              n;
    int              idx;
    logic [KeyW-1:0] k;
    r = $urandom_range(99);
    n = 0;
    k = '0;
    for (int i = 0; i < Depth; i++) n += int'(slot_used[i]);
    if (n != 0 && r < ((mix == MixFill) ? 10 : 55)) begin
      idx = $urandom_range(n - 1);
      for (int i = 0; i < Depth; i++) begin
        if (slot_used[i]) begin
          if (idx == 0) k = slot_key[i];
          idx--;
        end
      end
      return k;
    end
    if (r < ((mix == MixFill) ? 25 : 80)) return key_pool[$urandom_range(PoolN - 1)];
    return $urandom();
  endfunction

  function automatic logic [PayW-1:0] pick_payload();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic log_mismatch(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    if (mismatch_cnt < LogLimit)
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_rsp();
    rsp_t want;
    if (pending_rsp_q.size() == 0) begin
      log_mismatch("response with no request pending", 64'(rsp_bus.status), '0);
      return;
    end
    want = pending_rsp_q.pop_front();
    if (rsp_bus.status !== want.status)
      log_mismatch("status", 64'(rsp_bus.status), 64'(want.status));
    if (rsp_bus.found_payload !== want.found_payload)
      log_mismatch("found_payload", rsp_bus.found_payload, want.found_payload);
    if (rsp_bus.valid_count !== want.valid_count)
      log_mismatch("valid_count", 64'(rsp_bus.valid_count), 64'(want.valid_count));
    if (rsp_bus.empty_count !== want.empty_count)
      log_mismatch("empty_count", 64'(rsp_bus.empty_count), 64'(want.empty_count));
  endtask

  task automatic issue_req(input logic [CmdW-1:0] op, input logic [KeyW-1:0] k,
                           input logic [PayW-1:0] p, input bit fixed, input rsp_t want);
    rsp_t model_rsp;
    if (!steady && $urandom_range(99) < 25) begin
      req_bus.valid <= 1'b0;
      repeat (($urandom_range(3) == 0) ? $urandom_range(2 * Depth, 1) : $urandom_range(3, 1))
        @(posedge clk_i);
    end
    req_bus.valid         <= 1'b1;
    req_bus.cmd           <= op;
    req_bus.entry_key     <= k;
    req_bus.entry_payload <= p;
    do @(posedge clk_i); while (!req_bus.ready);
    model_rsp = apply_table_cmd(op, k, p);
    pending_rsp_q.push_back(fixed ? want : model_rsp);
  endtask

  // Response side: random backpressure, occasional long stalls; always ready when steady.
  initial begin
    int unsigned hold_cycles;
    hold_cycles = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_bus.valid && rsp_bus.ready) check_rsp();
      if (steady) begin
        rsp_bus.ready <= 1'b1;
      end else if (hold_cycles != 0) begin
        hold_cycles--;
        rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(99) < 25) begin
        hold_cycles = ($urandom_range(19) == 0) ? $urandom_range(3 * Depth, Depth)
                                                : $urandom_range(2, 0);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    rsp_t        want;
    step_t       row;
    mix_e        mix;
    logic [CmdW-1:0] op;

    rst_ni                <= 1'b0;
    req_bus.valid         <= 1'b0;
    req_bus.cmd           <= CmdAdd;
    req_bus.entry_key     <= '0;
    req_bus.entry_payload <= '0;
    for (int i = 0; i < Depth; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_pay[i]  = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < PoolN; i++) key_pool[i] = $urandom();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i]) begin
      row                = directed_steps[i];
      want.status        = row.status;
      want.found_payload = row.found_payload;
      want.valid_count   = row.valid_count;
      want.empty_count   = row.empty_count;
      issue_req(row.cmd, row.key, row.payload, row.fixed, want);
    end

    for (int n = 0; n < RandItems; n++) begin
      steady = (n >= 700 && n < 1000);
      case ((n / PhaseLen) % 4)
        0:       mix = MixFill;
        2:       mix = MixDrain;
        default: mix = MixBalanced;
      endcase
      op = pick_cmd(mix);
      issue_req(op, pick_key(mix), pick_payload(), 1'b0, '0);
    end

    steady = 1'b0;
    req_bus.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 8) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_rsp_q.size() == 0) begin
      $display("PASS keyed_entry_table");
    end else begin
      $display("FAIL keyed_entry_table");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL keyed_entry_table");
    $finish;
  end

endmodule
